>>> design/pugi_pkg.sv
// ----------------------------------------------------------------------------
// pugi_pkg
// shared types, codes and sizes of the piecewise uniform grid index core
// ----------------------------------------------------------------------------
package pugi_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned NodeW     = 14;
  localparam int unsigned CountW    = 13;
  localparam int unsigned SegCntW   = 2;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned MaxNodes  = 4096;
  localparam int unsigned MaxSegs   = 3;
  localparam int unsigned SpanW     = 12;
  localparam int unsigned DiffW     = 33;
  localparam int unsigned ProdW     = 46;
  localparam int unsigned NumW      = 47;
  localparam int unsigned DvsW      = 34;
  localparam int unsigned QuoW      = 33;

  localparam logic [CfgIdxW-1:0] CFG_BOUND_A   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BOUND_B   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BOUND_C   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BOUND_D   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NODES_1ST = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_NODES_2ND = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_NODES_3RD = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SEG_COUNT = 3'd7;

  localparam logic [CoordW-1:0]  RST_BOUND_A = 32'h0000_0000;
  localparam logic [CoordW-1:0]  RST_BOUND_B = 32'h0001_0000;
  localparam logic [CoordW-1:0]  RST_BOUND_C = 32'h0002_0000;
  localparam logic [CoordW-1:0]  RST_BOUND_D = 32'h0003_0000;
  localparam logic [CountW-1:0]  RST_NODES   = 13'd2;
  localparam logic [SegCntW-1:0] RST_SEGS    = 2'd1;

  localparam logic ACT_LOCATE = 1'b0;
  localparam logic ACT_NODE   = 1'b1;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_ABOVE     = 2'd1;
  localparam logic [StatusW-1:0] ST_BELOW     = 2'd2;
  localparam logic [StatusW-1:0] ST_NODE_OOR  = 2'd3;

  typedef struct packed {
    logic                action;
    logic [StatusW-1:0]  st;
    logic [NodeW-1:0]    first;
    logic [CoordW-1:0]   lo;
    logic                neg;
  } pugi_side_t;

endpackage

>>> design/pugi_in_if.sv
// ----------------------------------------------------------------------------
// pugi_in_if
// query word channel: action, coordinate and node index
// ----------------------------------------------------------------------------
interface pugi_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic signed [pugi_pkg::CoordW-1:0] coordinate_in;
  logic [pugi_pkg::NodeW-1:0]       node_in;

  modport source (output valid, action, coordinate_in, node_in, input ready);
  modport sink   (input valid, action, coordinate_in, node_in, output ready);
endinterface

>>> design/pugi_out_if.sv
// ----------------------------------------------------------------------------
// pugi_out_if
// result word channel: node, coordinate and status
// ----------------------------------------------------------------------------
interface pugi_out_if;
  logic                               valid;
  logic                               ready;
  logic [pugi_pkg::NodeW-1:0]         node_out;
  logic signed [pugi_pkg::CoordW-1:0] coordinate_out;
  logic [pugi_pkg::StatusW-1:0]       status;

  modport source (output valid, node_out, coordinate_out, status, input ready);
  modport sink   (input valid, node_out, coordinate_out, status, output ready);
endinterface

>>> design/pugi_div.sv
// ----------------------------------------------------------------------------
// pugi_div
// pipelined restoring divider, one quotient bit per stage, with side data
// ----------------------------------------------------------------------------
module pugi_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [pugi_pkg::ProdW-1:0]    dividend_i,
  input  logic [pugi_pkg::DvsW-1:0]     divisor_i,
  input  pugi_pkg::pugi_side_t          side_i,
  output logic                          valid_o,
  output logic [pugi_pkg::QuoW-1:0]     quo_o,
  output logic                          rem_nz_o,
  output pugi_pkg::pugi_side_t          side_o
);

  localparam int unsigned Steps = pugi_pkg::QuoW;
  localparam int unsigned DvsW  = pugi_pkg::DvsW;
  localparam int unsigned HighW = pugi_pkg::ProdW - Steps;

  logic                 v_q    [Steps+1];
  logic [DvsW-1:0]      rem_q  [Steps+1];
  logic [Steps-1:0]     dvd_q  [Steps+1];
  logic [Steps-1:0]     quo_q  [Steps+1];
  logic [DvsW-1:0]      dsr_q  [Steps+1];
  pugi_pkg::pugi_side_t side_q [Steps+1];

  logic [DvsW:0]        trial  [Steps];
  logic                 ge     [Steps];
  logic [DvsW:0]        diff   [Steps];

  always_comb begin
    for (int j = 0; j < Steps; j++) begin
      trial[j] = {rem_q[j], dvd_q[j][Steps-1]};
      ge[j]    = trial[j] >= {1'b0, dsr_q[j]};
      diff[j]  = trial[j] - {1'b0, dsr_q[j]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= Steps; j++) v_q[j] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int j = 1; j <= Steps; j++) v_q[j] <= v_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {{(DvsW-HighW){1'b0}}, dividend_i[pugi_pkg::ProdW-1:Steps]};
      dvd_q[0]  <= dividend_i[Steps-1:0];
      quo_q[0]  <= '0;
      dsr_q[0]  <= divisor_i;
      side_q[0] <= side_i;
      for (int j = 1; j <= Steps; j++) begin
        rem_q[j]  <= ge[j-1] ? diff[j-1][DvsW-1:0] : trial[j-1][DvsW-1:0];
        dvd_q[j]  <= {dvd_q[j-1][Steps-2:0], 1'b0};
        quo_q[j]  <= {quo_q[j-1][Steps-2:0], ge[j-1]};
        dsr_q[j]  <= dsr_q[j-1];
        side_q[j] <= side_q[j-1];
      end
    end
  end

  assign valid_o  = v_q[Steps];
  assign quo_o    = quo_q[Steps];
  assign rem_nz_o = |rem_q[Steps];
  assign side_o   = side_q[Steps];

endmodule

>>> design/piecewise_uniform_grid_index_core.sv
// ----------------------------------------------------------------------------
// piecewise_uniform_grid_index_core
// maps coordinates to nearest node and nodes to coordinates on a grid of up
// to three uniform segments
// ----------------------------------------------------------------------------
// stages: segment select, operands, product, divider, output register
// throughput: one word per cycle unless stalled; the 33-stage divider sets the depth
// a stall at the output holds the whole pipe, nothing lost or repeated
// reset: async active low, clears valid bits and loads default registers
// ----------------------------------------------------------------------------
module piecewise_uniform_grid_index_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pugi_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pugi_pkg::CoordW-1:0]     cfg_data_i,
  pugi_in_if.sink                         in_i,
  pugi_out_if.source                      out_o
);

  localparam int unsigned CW = pugi_pkg::CoordW;
  localparam int unsigned NW = pugi_pkg::NodeW;
  localparam int unsigned SW = pugi_pkg::SpanW;
  localparam int unsigned DW = pugi_pkg::DiffW;
  localparam int unsigned PW = pugi_pkg::ProdW;

  // configuration
  logic signed [CW-1:0]             bound_q [4];
  logic [pugi_pkg::CountW-1:0]      nodes_q [3];
  logic [pugi_pkg::SegCntW-1:0]     segs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q[0] <= pugi_pkg::RST_BOUND_A;
      bound_q[1] <= pugi_pkg::RST_BOUND_B;
      bound_q[2] <= pugi_pkg::RST_BOUND_C;
      bound_q[3] <= pugi_pkg::RST_BOUND_D;
      nodes_q[0] <= pugi_pkg::RST_NODES;
      nodes_q[1] <= pugi_pkg::RST_NODES;
      nodes_q[2] <= pugi_pkg::RST_NODES;
      segs_q     <= pugi_pkg::RST_SEGS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pugi_pkg::CFG_BOUND_A:   bound_q[0] <= cfg_data_i;
        pugi_pkg::CFG_BOUND_B:   bound_q[1] <= cfg_data_i;
        pugi_pkg::CFG_BOUND_C:   bound_q[2] <= cfg_data_i;
        pugi_pkg::CFG_BOUND_D:   bound_q[3] <= cfg_data_i;
        pugi_pkg::CFG_NODES_1ST: nodes_q[0] <= cfg_data_i[pugi_pkg::CountW-1:0];
        pugi_pkg::CFG_NODES_2ND: nodes_q[1] <= cfg_data_i[pugi_pkg::CountW-1:0];
        pugi_pkg::CFG_NODES_3RD: nodes_q[2] <= cfg_data_i[pugi_pkg::CountW-1:0];
        pugi_pkg::CFG_SEG_COUNT: segs_q     <= cfg_data_i[pugi_pkg::SegCntW-1:0];
        default: ;
      endcase
    end
  end

  // derived grid layout
  logic [SW-1:0]                nm1 [3];
  logic [NW-1:0]                first [3];
  logic [NW:0]                  total;
  logic [pugi_pkg::SegCntW-1:0] segs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (nodes_q[i] < pugi_pkg::CountW'(2)) begin
        nm1[i] = SW'(1);
      end else if (nodes_q[i] > pugi_pkg::CountW'(pugi_pkg::MaxNodes)) begin
        nm1[i] = SW'(pugi_pkg::MaxNodes - 1);
      end else begin
        nm1[i] = SW'(nodes_q[i] - pugi_pkg::CountW'(1));
      end
    end
    segs     = (segs_q == '0) ? pugi_pkg::SegCntW'(1) : segs_q;
    first[0] = '0;
    first[1] = NW'(nm1[0]);
    first[2] = NW'(nm1[0]) + NW'(nm1[1]);
    case (segs)
      2'd3:    total = {1'b0, first[2]} + (NW+1)'(nm1[2]) + (NW+1)'(1);
      2'd2:    total = {1'b0, first[1]} + (NW+1)'(nm1[1]) + (NW+1)'(1);
      default: total = (NW+1)'(nm1[0]) + (NW+1)'(1);
    endcase
  end

  logic en;
  logic out_v_q;
  assign en        = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  // stage 1: segment selection
  logic [1:0]               sel;
  logic [pugi_pkg::StatusW-1:0] st1;

  always_comb begin
    sel = 2'd0;
    st1 = pugi_pkg::ST_OK;
    if (in_i.action == pugi_pkg::ACT_LOCATE) begin
      if (in_i.coordinate_in <= bound_q[1]) begin
        sel = 2'd0;
      end else if (segs >= 2'd2 && in_i.coordinate_in <= bound_q[2]) begin
        sel = 2'd1;
      end else if (segs == 2'd3 && in_i.coordinate_in <= bound_q[3]) begin
        sel = 2'd2;
      end else begin
        st1 = pugi_pkg::ST_ABOVE;
      end
    end else begin
      if ({1'b0, in_i.node_in} >= total) begin
        st1 = pugi_pkg::ST_NODE_OOR;
      end else if (segs == 2'd3 && in_i.node_in >= first[2]) begin
        sel = 2'd2;
      end else if (segs >= 2'd2 && in_i.node_in >= first[1]) begin
        sel = 2'd1;
      end
    end
  end

  logic                 s1_v_q, s1_act_q;
  logic [1:0]           s1_st_q;
  logic signed [CW-1:0] s1_x_q, s1_lo_q, s1_hi_q;
  logic [NW-1:0]        s1_k_q, s1_first_q;
  logic [SW-1:0]        s1_nm1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_act_q   <= in_i.action;
      s1_st_q    <= st1;
      s1_x_q     <= in_i.coordinate_in;
      s1_k_q     <= in_i.node_in;
      s1_lo_q    <= bound_q[sel];
      s1_hi_q    <= bound_q[sel+2'd1];
      s1_nm1_q   <= nm1[sel];
      s1_first_q <= first[sel];
    end
  end

  // stage 2: multiplier operands
  logic signed [DW-1:0] s2_a_q, s2_len_q;
  logic [SW-1:0]        s2_b_q, s2_nm1_q;
  logic                 s2_v_q, s2_act_q;
  logic [1:0]           s2_st_q;
  logic [CW-1:0]        s2_lo_q;
  logic [NW-1:0]        s2_first_q;
  logic signed [DW-1:0] len2, xd2;
  logic [NW-1:0]        kd2;

  always_comb begin
    len2 = DW'(s1_hi_q) - DW'(s1_lo_q);
    xd2  = DW'(s1_x_q) - DW'(s1_lo_q);
    kd2  = s1_k_q - s1_first_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_a_q     <= (s1_act_q == pugi_pkg::ACT_NODE) ? len2 : xd2;
      s2_b_q     <= (s1_act_q == pugi_pkg::ACT_NODE) ? kd2[SW-1:0] : s1_nm1_q;
      s2_len_q   <= len2;
      s2_nm1_q   <= s1_nm1_q;
      s2_act_q   <= s1_act_q;
      s2_st_q    <= s1_st_q;
      s2_lo_q    <= s1_lo_q;
      s2_first_q <= s1_first_q;
    end
  end

  // stage 3: product
  logic signed [PW-1:0] s3_prod_q;
  logic signed [DW-1:0] s3_len_q;
  logic [SW-1:0]        s3_nm1_q;
  logic                 s3_v_q, s3_act_q;
  logic [1:0]           s3_st_q;
  logic [CW-1:0]        s3_lo_q;
  logic [NW-1:0]        s3_first_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_prod_q  <= s2_a_q * $signed({1'b0, s2_b_q});
      s3_len_q   <= s2_len_q;
      s3_nm1_q   <= s2_nm1_q;
      s3_act_q   <= s2_act_q;
      s3_st_q    <= s2_st_q;
      s3_lo_q    <= s2_lo_q;
      s3_first_q <= s2_first_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_i.valid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // divider operands
  logic signed [pugi_pkg::NumW-1:0] num;
  logic [PW-1:0]                    dvd;
  logic [pugi_pkg::DvsW-1:0]        dsr;
  logic [PW-1:0]                    pmag;
  pugi_pkg::pugi_side_t             side_in;

  always_comb begin
    num  = $signed({s3_prod_q, 1'b0}) + pugi_pkg::NumW'(s3_len_q);
    pmag = s3_prod_q[PW-1] ? PW'(-s3_prod_q) : PW'(s3_prod_q);
    side_in.action = s3_act_q;
    side_in.st     = s3_st_q;
    side_in.first  = s3_first_q;
    side_in.lo     = s3_lo_q;
    side_in.neg    = s3_prod_q[PW-1];
    if (s3_act_q == pugi_pkg::ACT_NODE) begin
      dvd = pmag;
      dsr = pugi_pkg::DvsW'(s3_nm1_q);
    end else begin
      if (num < 0 && s3_st_q == pugi_pkg::ST_OK) side_in.st = pugi_pkg::ST_BELOW;
      if (num < 0 || s3_len_q <= 0) begin
        dvd = '0;
        dsr = pugi_pkg::DvsW'(1);
      end else begin
        dvd = num[PW-1:0];
        dsr = {s3_len_q, 1'b0};
      end
    end
  end

  logic                       dv_v;
  logic [pugi_pkg::QuoW-1:0]  dv_quo;
  logic                       dv_rnz;
  pugi_pkg::pugi_side_t       dv_side;

  pugi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s3_v_q),
    .dividend_i (dvd),
    .divisor_i  (dsr),
    .side_i     (side_in),
    .valid_o    (dv_v),
    .quo_o      (dv_quo),
    .rem_nz_o   (dv_rnz),
    .side_o     (dv_side)
  );

  // output register
  logic [CW-1:0]                q32, qs;
  logic [NW-1:0]                node_d, node_q;
  logic [CW-1:0]                coord_d, coord_q;
  logic [pugi_pkg::StatusW-1:0] st_q;

  always_comb begin
    q32     = dv_quo[CW-1:0];
    qs      = dv_side.neg ? (~q32 + CW'(!dv_rnz)) : q32;
    node_d  = '0;
    coord_d = '0;
    if (dv_side.st == pugi_pkg::ST_OK) begin
      if (dv_side.action == pugi_pkg::ACT_NODE) begin
        coord_d = dv_side.lo + qs;
      end else begin
        node_d = dv_side.first + dv_quo[NW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q    <= dv_side.st;
      node_q  <= node_d;
      coord_q <= coord_d;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.node_out       = node_q;
  assign out_o.coordinate_out = coord_q;
  assign out_o.status         = st_q;

endmodule

>>> design/pugi_checker.sv
// ----------------------------------------------------------------------------
// pugi_checker
// port level checks of the grid index core
// ----------------------------------------------------------------------------
module pugi_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [pugi_pkg::NodeW-1:0]     node_out_i,
  input logic [pugi_pkg::CoordW-1:0]    coordinate_out_i,
  input logic [pugi_pkg::StatusW-1:0]   status_i
);

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken during output stall");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(node_out_i) && $stable(coordinate_out_i))
    else $error("stalled word changed");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != pugi_pkg::ST_OK |-> node_out_i == '0
      && coordinate_out_i == '0)
    else $error("error word carries data");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> node_out_i == '0 || coordinate_out_i == '0)
    else $error("both result fields set");

endmodule

bind piecewise_uniform_grid_index_core pugi_checker u_pugi_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .node_out_i       (out_o.node_out),
  .coordinate_out_i (out_o.coordinate_out),
  .status_i         (out_o.status)
);

>>> sim/piecewise_uniform_grid_index_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// piecewise_uniform_grid_index_core_test
// drives query words through the grid index core under several grid setups,
// predicts each result word in the bench and compares node, coordinate and
// status; both channels idle in random bursts except near the end
// ----------------------------------------------------------------------------
module piecewise_uniform_grid_index_core_test;

  typedef struct packed {
    logic [pugi_pkg::NodeW-1:0]   node;
    logic [pugi_pkg::CoordW-1:0]  coord;
    logic [pugi_pkg::StatusW-1:0] st;
  } grid_result_t;

  typedef struct {
    logic                        act;
    logic [pugi_pkg::CoordW-1:0] x;
    logic [pugi_pkg::NodeW-1:0]  k;
    bit                          typed;
    grid_result_t                res;
  } query_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [pugi_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [pugi_pkg::CoordW-1:0] cfg_data_i = '0;

  pugi_in_if  in_ch ();
  pugi_out_if out_ch ();

  piecewise_uniform_grid_index_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #1 clk_i = ~clk_i;

  logic [pugi_pkg::CoordW-1:0] grid_bound [4];
  logic [pugi_pkg::CountW-1:0] grid_nodes [3];
  logic [pugi_pkg::SegCntW-1:0] grid_segs;

  grid_result_t expected_words [$];
  int mismatches = 0;
  int words_seen = 0;
  int locates_sent = 0;
  int node_queries_sent = 0;
  bit calm = 1'b0;

  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q -= 1;
    return q;
  endfunction

  function automatic grid_result_t grid_lookup(logic act,
                                               logic [pugi_pkg::CoordW-1:0] xr,
                                               logic [pugi_pkg::NodeW-1:0] kr);
    grid_result_t r;
    longint b [4];
    longint n [3];
    longint first [3];
    longint total, x, lo, len, num, k, v;
    int s, seg;
    r = '0;
    s = grid_segs;
    if (s < 1) s = 1;
    if (s > pugi_pkg::MaxSegs) s = pugi_pkg::MaxSegs;
    for (int i = 0; i < 4; i++) b[i] = longint'($signed(grid_bound[i]));
    for (int i = 0; i < 3; i++) begin
      n[i] = grid_nodes[i];
      if (n[i] < 2) n[i] = 2;
      if (n[i] > pugi_pkg::MaxNodes) n[i] = pugi_pkg::MaxNodes;
    end
    first[0] = 0;
    for (int i = 1; i < 3; i++) first[i] = first[i-1] + n[i-1] - 1;
    total = first[s-1] + n[s-1];
    if (act == pugi_pkg::ACT_LOCATE) begin
      x = longint'($signed(xr));
      seg = -1;
      for (int i = 0; i < s; i++) begin
        if (seg < 0 && x <= b[i+1]) seg = i;
      end
      if (seg < 0) begin
        r.st = pugi_pkg::ST_ABOVE;
      end else begin
        lo = b[seg];
        len = b[seg+1] - lo;
        num = 2 * (x - lo) * (n[seg] - 1) + len;
        if (num < 0) r.st = pugi_pkg::ST_BELOW;
        else r.node = pugi_pkg::NodeW'(first[seg] + ((len > 0) ? num / (2 * len) : 0));
      end
    end else begin
      k = kr;
      if (k >= total) begin
        r.st = pugi_pkg::ST_NODE_OOR;
      end else begin
        seg = 0;
        for (int i = 0; i < s; i++) if (first[i] <= k) seg = i;
        lo = b[seg];
        len = b[seg+1] - lo;
        v = lo + floor_quot((k - first[seg]) * len, n[seg] - 1);
        r.coord = pugi_pkg::CoordW'(v);
      end
    end
    return r;
  endfunction

  task automatic write_reg(logic [pugi_pkg::CfgIdxW-1:0] idx,
                           logic [pugi_pkg::CoordW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pugi_pkg::CFG_BOUND_A:   grid_bound[0] = val;
      pugi_pkg::CFG_BOUND_B:   grid_bound[1] = val;
      pugi_pkg::CFG_BOUND_C:   grid_bound[2] = val;
      pugi_pkg::CFG_BOUND_D:   grid_bound[3] = val;
      pugi_pkg::CFG_NODES_1ST: grid_nodes[0] = val[pugi_pkg::CountW-1:0];
      pugi_pkg::CFG_NODES_2ND: grid_nodes[1] = val[pugi_pkg::CountW-1:0];
      pugi_pkg::CFG_NODES_3RD: grid_nodes[2] = val[pugi_pkg::CountW-1:0];
      pugi_pkg::CFG_SEG_COUNT: grid_segs = val[pugi_pkg::SegCntW-1:0];
      default: ;
    endcase
  endtask

  task automatic setup_grid(logic [pugi_pkg::CoordW-1:0] a, logic [pugi_pkg::CoordW-1:0] b,
                            logic [pugi_pkg::CoordW-1:0] c, logic [pugi_pkg::CoordW-1:0] d,
                            int n1, int n2, int n3, int segs);
    in_ch.valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (45) @(negedge clk_i);
    write_reg(pugi_pkg::CFG_BOUND_A, a);
    write_reg(pugi_pkg::CFG_BOUND_B, b);
    write_reg(pugi_pkg::CFG_BOUND_C, c);
    write_reg(pugi_pkg::CFG_BOUND_D, d);
    write_reg(pugi_pkg::CFG_NODES_1ST, pugi_pkg::CoordW'(n1));
    write_reg(pugi_pkg::CFG_NODES_2ND, pugi_pkg::CoordW'(n2));
    write_reg(pugi_pkg::CFG_NODES_3RD, pugi_pkg::CoordW'(n3));
    write_reg(pugi_pkg::CFG_SEG_COUNT, pugi_pkg::CoordW'(segs));
  endtask

  task automatic send_query(logic act, logic [pugi_pkg::CoordW-1:0] x,
                            logic [pugi_pkg::NodeW-1:0] k,
                            bit typed, grid_result_t res);
    grid_result_t pred;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.coordinate_in <= x;
    in_ch.node_in <= k;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pred = grid_lookup(act, x, k);
    if (typed && pred != res) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with prediction: row %h predicted %h", res, pred);
    end
    expected_words.push_back(pred);
    if (act == pugi_pkg::ACT_LOCATE) locates_sent++;
    else node_queries_sent++;
    @(negedge clk_i);
  endtask

  // accepted result words
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      grid_result_t got;
      got.node = out_ch.node_out;
      got.coord = out_ch.coordinate_out;
      got.st = out_ch.status;
      words_seen++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        grid_result_t want;
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: node %0d/%0d coord %h/%h status %0d/%0d (exp/act)",
                     want.node, got.node, want.coord, got.coord, want.st, got.st);
        end
      end
    end
  end

  // result-side stalls
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #4000000;
    $display("piecewise_uniform_grid_index_core_test failed");
    $finish;
  end

  task automatic random_queries(int count);
    logic [pugi_pkg::CoordW-1:0] x;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        x = grid_bound[$urandom_range(0, 3)]
            + pugi_pkg::CoordW'($urandom_range(0, 200000)) - 100000;
        send_query(pugi_pkg::ACT_LOCATE, x, '0, 1'b0, '0);
      end else if (pick < 6) begin
        send_query(pugi_pkg::ACT_LOCATE, $urandom, '0, 1'b0, '0);
      end else if (pick < 9) begin
        send_query(pugi_pkg::ACT_NODE, $urandom,
                   pugi_pkg::NodeW'($urandom_range(0, 40)), 1'b0, '0);
      end else begin
        send_query(pugi_pkg::ACT_NODE, $urandom, pugi_pkg::NodeW'($urandom), 1'b0, '0);
      end
    end
  endtask

  query_row_t rows [$];

  initial begin
    grid_bound[0] = pugi_pkg::RST_BOUND_A;
    grid_bound[1] = pugi_pkg::RST_BOUND_B;
    grid_bound[2] = pugi_pkg::RST_BOUND_C;
    grid_bound[3] = pugi_pkg::RST_BOUND_D;
    for (int i = 0; i < 3; i++) grid_nodes[i] = pugi_pkg::RST_NODES;
    grid_segs = pugi_pkg::RST_SEGS;
    in_ch.valid = 1'b0;
    in_ch.action = pugi_pkg::ACT_LOCATE;
    in_ch.coordinate_in = '0;
    in_ch.node_in = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // after reset: one segment 0..1.0, two nodes
    rows = '{
      '{pugi_pkg::ACT_LOCATE, 32'h0000_0000, 14'd0, 1'b1, '{14'd0, 32'd0, pugi_pkg::ST_OK}},
      '{pugi_pkg::ACT_LOCATE, 32'h0000_8000, 14'd0, 1'b1, '{14'd1, 32'd0, pugi_pkg::ST_OK}},
      '{pugi_pkg::ACT_LOCATE, 32'h0000_7FFF, 14'd0, 1'b1, '{14'd0, 32'd0, pugi_pkg::ST_OK}},
      '{pugi_pkg::ACT_LOCATE, 32'h0001_0000, 14'd0, 1'b1, '{14'd1, 32'd0, pugi_pkg::ST_OK}},
      '{pugi_pkg::ACT_LOCATE, 32'h0001_0001, 14'd0, 1'b1,
        '{14'd0, 32'd0, pugi_pkg::ST_ABOVE}},
      '{pugi_pkg::ACT_LOCATE, 32'h7FFF_FFFF, 14'd0, 1'b1,
        '{14'd0, 32'd0, pugi_pkg::ST_ABOVE}},
      '{pugi_pkg::ACT_LOCATE, 32'hFFFF_8000, 14'd0, 1'b1, '{14'd0, 32'd0, pugi_pkg::ST_OK}},
      '{pugi_pkg::ACT_LOCATE, 32'hFFFF_7FFF, 14'd0, 1'b1,
        '{14'd0, 32'd0, pugi_pkg::ST_BELOW}},
      '{pugi_pkg::ACT_LOCATE, 32'h8000_0000, 14'd0, 1'b1,
        '{14'd0, 32'd0, pugi_pkg::ST_BELOW}},
      '{pugi_pkg::ACT_NODE, 32'hFFFF_FFFF, 14'd0, 1'b1,
        '{14'd0, 32'h0000_0000, pugi_pkg::ST_OK}},
      '{pugi_pkg::ACT_NODE, 32'h0000_0000, 14'd1, 1'b1,
        '{14'd0, 32'h0001_0000, pugi_pkg::ST_OK}},
      '{pugi_pkg::ACT_NODE, 32'h0000_0000, 14'd2, 1'b1,
        '{14'd0, 32'd0, pugi_pkg::ST_NODE_OOR}},
      '{pugi_pkg::ACT_NODE, 32'h0000_0000, 14'h3FFF, 1'b1,
        '{14'd0, 32'd0, pugi_pkg::ST_NODE_OOR}}
    };
    foreach (rows[i])
      send_query(rows[i].act, rows[i].x, rows[i].k, rows[i].typed, rows[i].res);

    // three segments, shared end nodes, a degenerate zero-length segment
    setup_grid(32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, 32'h0005_0000, 5, 3, 7, 3);
    for (int k = 0; k < 14; k++)
      send_query(pugi_pkg::ACT_NODE, '0, pugi_pkg::NodeW'(k), 1'b0, '0);
    send_query(pugi_pkg::ACT_LOCATE, 32'h0000_0000, '0, 1'b0, '0);
    random_queries(100);

    // widest bounds, largest node counts, saturating counts, three segments
    setup_grid(32'h8000_0000, 32'hC000_0000, 32'h4000_0000, 32'h7FFF_FFFF,
               4096, 8191, 0, 3);
    for (int k = 0; k < 6; k++)
      send_query(pugi_pkg::ACT_NODE, '0, pugi_pkg::NodeW'($urandom_range(0, 16383)),
                 1'b0, '0);
    send_query(pugi_pkg::ACT_NODE, '0, 14'd12286, 1'b0, '0);
    send_query(pugi_pkg::ACT_NODE, '0, 14'd12287, 1'b0, '0);
    send_query(pugi_pkg::ACT_LOCATE, 32'h8000_0000, '0, 1'b0, '0);
    send_query(pugi_pkg::ACT_LOCATE, 32'h7FFF_FFFF, '0, 1'b0, '0);
    random_queries(150);

    // unordered bounds, zero segment count
    setup_grid(32'h0010_0000, 32'h0008_0000, 32'h0020_0000, 32'h0001_0000, 9, 2, 4, 0);
    random_queries(100);

    // random grids
    for (int p = 0; p < 3; p++) begin
      setup_grid($urandom, $urandom, $urandom, $urandom,
                 $urandom_range(2, 40), $urandom_range(0, 8191), $urandom_range(2, 9),
                 $urandom_range(0, 3));
      random_queries(60);
    end

    setup_grid(32'hFFFE_0000, 32'h0000_1000, 32'h0003_0000, 32'h0003_0003,
               17, 100, 3, 2);
    random_queries(80);
    calm = 1'b1;
    random_queries(90);
    in_ch.valid <= 1'b0;

    wait (expected_words.size() == 0);
    repeat (60) @(negedge clk_i);
    $display("ran %0d locate and %0d node queries over the reset grid and seven more",
             locates_sent, node_queries_sent);
    $display("setups, %0d words checked", words_seen);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("piecewise_uniform_grid_index_core_test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("piecewise_uniform_grid_index_core_test failed");
    end
    $finish;
  end
endmodule

>>> sim.f
design/pugi_pkg.sv
design/pugi_in_if.sv
design/pugi_out_if.sv
design/pugi_div.sv
design/piecewise_uniform_grid_index_core.sv
design/pugi_checker.sv
sim/piecewise_uniform_grid_index_core_test.sv
